// ----- sv/ubtf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ubtf_pkg;

  localparam int TX_DEPTH_DEF = 32;
  localparam int RX_DEPTH_DEF = 32;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd10;

  // request opcodes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_READY = 2'd1;
  localparam logic [1:0] OP_RX    = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_PUSH  = 2'd0;
  localparam logic [1:0] KIND_LINE  = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;
  localparam logic [1:0] KIND_FRAME = 2'd3;

  localparam logic [4:0] PENDING_MAX = 5'd31;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data;
  } request_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_out;
    logic       accepted;
    logic       last;
    logic [4:0] pending_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TX_WAIT,
    ST_DELIVER,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [7:0] data;
  } tx_cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       armed;
    logic [4:0] pending;
    logic [4:0] pending_inc;
  } tx_stat_t;

  typedef struct packed {
    logic       store;
    logic       tick;
    logic       rd_en;
    logic       clear;
    logic [7:0] data;
  } rx_cmd_t;

  typedef struct packed {
    logic full;
    logic fire;
    logic rd_last;
  } rx_stat_t;

  typedef struct packed {
    logic valid;
    logic from_rx;
    logic last;
  } rd_tag_t;

endpackage
`default_nettype wire

// ----- sv/ubtf_tx_ring.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubtf_tx_ring #(
  parameter int TX_DEPTH = ubtf_pkg::TX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ubtf_pkg::tx_cmd_t  cmd,
  output ubtf_pkg::tx_stat_t      stat,
  output logic [7:0]              rd_data
);
  import ubtf_pkg::*;

  localparam int PW = $clog2(TX_DEPTH);
  localparam int CW = (PW + 1 > 5) ? PW + 1 : 5;

  logic [7:0]    mem [TX_DEPTH];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic          armed;
  logic [PW-1:0] head_inc;
  logic [PW-1:0] tail_inc;
  logic [CW-1:0] count;

  assign head_inc = (head == PW'(TX_DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PW'(TX_DEPTH - 1)) ? '0 : tail + 1'b1;

  // occupancy with wrap
  always_comb begin
    if (head >= tail) begin
      count = CW'(head) - CW'(tail);
    end else begin
      count = CW'(head) + CW'(TX_DEPTH) - CW'(tail);
    end
  end

  always_comb begin
    stat.full        = (head_inc == tail);
    stat.empty       = (head == tail);
    stat.armed       = armed;
    stat.pending     = (count > CW'(PENDING_MAX)) ? PENDING_MAX : count[4:0];
    stat.pending_inc = (count >= CW'(PENDING_MAX)) ? PENDING_MAX : count[4:0] + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      armed <= 1'b0;
    end else if (cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      armed <= 1'b0;
    end else begin
      if (cmd.push) begin
        head  <= head_inc;
        armed <= 1'b1;
      end
      if (cmd.pop) begin
        tail <= tail_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[head] <= cmd.data;
    end
    if (cmd.pop) begin
      rd_data <= mem[tail];
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !stat.full) else $error("push into full ring");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (armed && !stat.empty)) else $error("pop from empty or disarmed ring");
  a_push_arms: assert property (@(posedge clk) disable iff (rst)
    (cmd.push && !cmd.clear) |=> (armed && !stat.empty))
    else $error("push did not arm transmit");
  a_clear_resets: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (head == '0 && tail == '0 && !armed))
    else $error("clear left ring state behind");
`endif
endmodule
`default_nettype wire

// ----- sv/ubtf_rx_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ubtf_rx_store #(
  parameter int RX_DEPTH = ubtf_pkg::RX_DEPTH_DEF,
  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ubtf_pkg::rx_cmd_t  cmd,
  input  wire logic [AW-1:0]      rd_addr,
  input  wire logic [15:0]        idle_timeout,
  output ubtf_pkg::rx_stat_t      stat,
  output logic [7:0]              rd_data
);
  import ubtf_pkg::*;

  localparam int FW = $clog2(RX_DEPTH + 1);

  logic [7:0]    mem [RX_DEPTH];
  logic [FW-1:0] fill;
  logic          pending;
  logic [16:0]   idle_count;

  always_comb begin
    stat.full    = (fill == FW'(RX_DEPTH));
    stat.fire    = pending && ({1'b0, idle_timeout} <= idle_count);
    stat.rd_last = ((FW'(rd_addr) + 1'b1) == fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      pending    <= 1'b0;
      idle_count <= '0;
    end else begin
      if (cmd.store) begin
        fill       <= fill + 1'b1;
        pending    <= 1'b1;
        idle_count <= '0;
      end else if (cmd.tick && pending) begin
        if (stat.fire) begin
          pending    <= 1'b0;
          idle_count <= '0;
        end else if (idle_count != 17'h1FFFF) begin
          idle_count <= idle_count + 17'd1;
        end
      end
      if (cmd.clear) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      mem[fill[AW-1:0]] <= cmd.data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_no_store_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !stat.full) else $error("store into full buffer");
  a_read_in_fill: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (FW'(rd_addr) < fill)) else $error("read beyond fill");
  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.tick && stat.fire && !cmd.store) |=> (!pending && idle_count == '0))
    else $error("delivery left timer running");
  a_pending_nonempty: assert property (@(posedge clk) disable iff (rst)
    pending |-> (fill != '0)) else $error("frame pending with empty buffer");
`endif
endmodule
`default_nettype wire

// ----- sv/uart_buffered_tx_rx_framer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Buffered UART framer. A request word (start while busy is low) is one event:
// push a transmit byte, transmitter ready, byte received, or tick. Results come
// out on result with result_valid high for exactly one cycle each; the receiver
// cannot stall, so sample every strobe. A push gives one status word on the
// cycle after it is taken and busy stays low. A ready that finds a byte reads
// the transmit ring through its registered read port: busy holds through
// ST_TX_WAIT and the byte comes out as a line word once the read data is back.
// A ready on an empty ring gives an idle word in the cycle after; a ready while
// disarmed, a received byte and a quiet tick give nothing and leave busy low. A
// tick that hits the idle timeout streams the held frame out of the receive
// buffer, one byte per cycle through its single read port: each byte passes the
// read register and the result register, busy holds through ST_DELIVER and
// ST_FLUSH, and the last byte is flagged. Bytes received while transmit is
// armed or while the buffer is full are dropped. cfg_data sets idle_timeout
// (reset 10 ticks); write it only while no request is in flight. No clearing
// pass after reset: both buffers are addressed only where written.
module uart_buffered_tx_rx_framer_top #(
  parameter int TX_DEPTH = ubtf_pkg::TX_DEPTH_DEF,
  parameter int RX_DEPTH = ubtf_pkg::RX_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire ubtf_pkg::request_t request,
  output logic                    result_valid,
  output ubtf_pkg::result_t       result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);
  import ubtf_pkg::*;

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  state_t        state;
  state_t        state_next;
  logic [AW-1:0] idx;
  logic [AW-1:0] idx_next;
  rd_tag_t       tag;
  rd_tag_t       tag_next;
  logic [15:0]   idle_timeout;
  logic          accept;
  logic          res_load;
  result_t       res_next;

  tx_cmd_t       tx_cmd;
  tx_stat_t      tx_stat;
  logic [7:0]    tx_rd_data;
  rx_cmd_t       rx_cmd;
  rx_stat_t      rx_stat;
  logic [7:0]    rx_rd_data;

  ubtf_tx_ring #(
    .TX_DEPTH(TX_DEPTH)
  ) u_tx (
    .clk     (clk),
    .rst     (rst),
    .cmd     (tx_cmd),
    .stat    (tx_stat),
    .rd_data (tx_rd_data)
  );

  ubtf_rx_store #(
    .RX_DEPTH(RX_DEPTH)
  ) u_rx (
    .clk          (clk),
    .rst          (rst),
    .cmd          (rx_cmd),
    .rd_addr      (idx),
    .idle_timeout (idle_timeout),
    .stat         (rx_stat),
    .rd_data      (rx_rd_data)
  );

  // config register: always ready; user writes only while quiet (not enforced)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      idle_timeout <= cfg_data;
    end
  end

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // sequencer: decode the request, then drive memory reads until done
  always_comb begin
    state_next = state;
    idx_next   = idx;
    tag_next   = '0;
    res_load   = 1'b0;
    res_next   = '0;
    tx_cmd     = '0;
    rx_cmd     = '0;
    tx_cmd.data = request.data;
    rx_cmd.data = request.data;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (request.op)
            OP_PUSH: begin
              res_load      = 1'b1;
              res_next.kind = KIND_PUSH;
              if (!tx_stat.full) begin
                tx_cmd.push            = 1'b1;
                res_next.accepted      = 1'b1;
                res_next.pending_count = tx_stat.pending_inc;
              end else begin
                res_next.pending_count = tx_stat.pending;
              end
            end
            OP_READY: begin
              if (tx_stat.armed) begin
                if (!tx_stat.empty) begin
                  // read oldest byte; the result word is formed once the read data is back
                  tx_cmd.pop    = 1'b1;
                  tag_next.valid = 1'b1;
                  state_next    = ST_TX_WAIT;
                end else begin
                  tx_cmd.clear  = 1'b1;
                  res_load      = 1'b1;
                  res_next.kind = KIND_IDLE;
                end
              end
            end
            OP_RX: begin
              rx_cmd.store = !tx_stat.armed && !rx_stat.full;
            end
            OP_TICK: begin
              rx_cmd.tick = 1'b1;
              if (rx_stat.fire) begin
                idx_next   = '0;
                state_next = ST_DELIVER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TX_WAIT: begin
        state_next = ST_IDLE;
      end
      ST_DELIVER: begin
        // issue one frame read per cycle
        rx_cmd.rd_en     = 1'b1;
        tag_next.valid   = 1'b1;
        tag_next.from_rx = 1'b1;
        tag_next.last    = rx_stat.rd_last;
        if (rx_stat.rd_last) begin
          state_next = ST_FLUSH;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_FLUSH: begin
        // last byte is leaving; empty the buffer
        rx_cmd.clear = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // read data is back: form the result word
    if (tag.valid) begin
      res_load               = 1'b1;
      res_next.kind          = tag.from_rx ? KIND_FRAME : KIND_LINE;
      res_next.data_out      = tag.from_rx ? rx_rd_data : tx_rd_data;
      res_next.last          = tag.last;
      res_next.pending_count = tx_stat.pending;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      tag          <= '0;
      result_valid <= 1'b0;
      idx          <= '0;
    end else begin
      state        <= state_next;
      tag          <= tag_next;
      result_valid <= res_load;
      idx          <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_tag_gives_result: assert property (@(posedge clk) disable iff (rst)
    tag.valid |=> result_valid) else $error("read data dropped");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == KIND_IDLE) |-> (result.pending_count == 5'd0))
    else $error("idle reported with bytes pending");
  a_flush_returns: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |=> (state == ST_IDLE && result_valid && result.last))
    else $error("frame did not end on a last byte");
  a_no_tag_in_idle_accept: assert property (@(posedge clk) disable iff (rst)
    accept |-> !tag.valid) else $error("result collision on accept");
`endif
endmodule
`default_nettype wire
